FILE: rtl/block_directory_validator_core_defines.svh
// ----------------------------------------------------------------------------
// block_directory_validator_core_defines.svh
// Assertion macros used by the checker file of the directory validator.
// ----------------------------------------------------------------------------
`ifndef BLOCK_DIRECTORY_VALIDATOR_CORE_DEFINES_SVH
`define BLOCK_DIRECTORY_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication, expects clk and rst_n in scope
`define BDV_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, expects clk and rst_n in scope
`define BDV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bdv_pkg.sv
// ----------------------------------------------------------------------------
// bdv_pkg
// Types, constants and status codes of the block directory validator.
// ----------------------------------------------------------------------------
`default_nettype none

package bdv_pkg;

    localparam int MAX_ENTRIES = 256;
    localparam int ALIGN_BYTES = 8;          // power of two
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = 9;
    localparam int ID_W        = 32;
    localparam int DATA_W      = 64;
    localparam int STATUS_W    = 4;
    localparam int CFG_IDX_W   = 4;

    localparam logic [DATA_W-1:0]    ALIGN_MASK = DATA_W'(ALIGN_BYTES - 1);
    localparam logic [IDX_W-1:0]     INDEX_MAX  = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SIZE = CFG_IDX_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 4'd0,
        ST_MISALIGNED  = 4'd1,
        ST_PAST_END    = 4'd2,
        ST_PRODUCT     = 4'd3,
        ST_MISMATCH    = 4'd4,
        ST_OVER_HEADER = 4'd5,
        ST_DUPLICATE   = 4'd6,
        ST_OVERLAP     = 4'd7,
        ST_FULL        = 4'd8,
        ST_SKIPPED     = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARITH,
        S_SCAN,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic              first_entry;
        logic [ID_W-1:0]   block_id;
        logic [DATA_W-1:0] block_offset;
        logic [DATA_W-1:0] block_length;
        logic [DATA_W-1:0] element_count;
        logic [DATA_W-1:0] element_size;
    } item_t;

    // one table row: end offset is stored instead of the length
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] end_off;
        logic              nonempty;
    } entry_t;

    typedef struct packed {
        logic    done;
        status_t code;
    } check_res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

endpackage

`default_nettype wire

FILE: rtl/bdv_ifs.sv
// ----------------------------------------------------------------------------
// bdv_ifs
// Valid/ready channels of the validator: directory entries, status, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdv_item_if import bdv_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              first_entry;
    logic [ID_W-1:0]   block_id;
    logic [DATA_W-1:0] block_offset;
    logic [DATA_W-1:0] block_length;
    logic [DATA_W-1:0] element_count;
    logic [DATA_W-1:0] element_size;

    modport source (
        output valid, first_entry, block_id, block_offset, block_length,
               element_count, element_size,
        input  ready
    );
    modport sink (
        input  valid, first_entry, block_id, block_offset, block_length,
               element_count, element_size,
        output ready
    );
endinterface

interface bdv_result_if import bdv_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    entry_index;

    modport source (output valid, status, entry_index, input ready);
    modport sink   (input valid, status, entry_index, output ready);
endinterface

interface bdv_cfg_if import bdv_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/block_directory_validator_core.sv
// ----------------------------------------------------------------------------
// block_directory_validator_core
// Checks block directory entries and returns one status per entry.
// ----------------------------------------------------------------------------
// One entry is handled at a time. An entry that is skipped or finds the table
// full goes straight to the finish state; any other first passes through the
// arithmetic checks and, if they pass, a scan over the N entries stored so far
// (at most 255), which a duplicate or overlap ends early. The finish state
// waits while the status side holds off the previous status. The table scan
// reads one stored entry per cycle through the single read port of the entry
// RAM; the 64x64 product is built on one 32x32 multiplier from four partial
// products. The next entry is taken while the previous status still waits in
// the output register. The entry RAM needs no clearing pass: only rows below
// the fill count are ever read.
`default_nettype none

module block_directory_validator_core import bdv_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bdv_item_if.sink     item,
    bdv_result_if.source result,
    bdv_cfg_if.sink      cfg
);

    fsm_state_t       state_reg, state_next;
    item_t            item_reg;
    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [IDX_W-1:0] seen_index_reg, seen_index_next;
    logic             failed_reg, failed_next;
    status_t          code_reg, code_next;
    logic [IDX_W-1:0] pos_reg;
    logic             out_valid_reg;
    status_t          out_status_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [DATA_W-1:0] file_limit_reg;
    logic [DATA_W-1:0] header_limit_reg;

    logic             accept;
    logic [CNT_W-1:0] count_eff;
    logic [IDX_W-1:0] seen_eff;
    logic             failed_eff;
    logic             arith_start;
    logic             scan_start;
    logic             load_out;
    check_res_t       arith_res;
    check_res_t       scan_res;
    logic [DATA_W-1:0] arith_end;
    entry_t           probe;
    ram_rd_t          ram_rd;
    ram_wr_t          ram_wr;
    entry_t           ram_rd_data;

    assign item.ready = state_reg == S_IDLE;
    assign accept     = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // a first entry starts from an empty directory
    assign count_eff  = item.first_entry ? '0   : stored_count_reg;
    assign seen_eff   = item.first_entry ? '0   : seen_index_reg;
    assign failed_eff = item.first_entry ? 1'b0 : failed_reg;

    assign probe = '{
        id:       item_reg.block_id,
        off:      item_reg.block_offset,
        end_off:  arith_end,
        nonempty: item_reg.block_length != '0
    };

    bdv_arith_check u_arith (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (arith_start),
        .item         (item_reg),
        .file_limit   (file_limit_reg),
        .header_limit (header_limit_reg),
        .res          (arith_res),
        .end_off      (arith_end)
    );

    bdv_table_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .count   (stored_count_reg),
        .probe   (probe),
        .rd      (ram_rd),
        .rd_data (ram_rd_data),
        .res     (scan_res)
    );

    bdv_entry_ram u_ram (
        .clk     (clk),
        .rd      (ram_rd),
        .wr      (ram_wr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next        = state_reg;
        code_next         = code_reg;
        failed_next       = failed_reg;
        stored_count_next = stored_count_reg;
        seen_index_next   = seen_index_reg;
        arith_start       = 1'b0;
        scan_start        = 1'b0;
        load_out          = 1'b0;
        ram_wr            = '{we: 1'b0, addr: stored_count_reg[ADDR_W-1:0], data: probe};

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    stored_count_next = count_eff;
                    seen_index_next   = (seen_eff == INDEX_MAX) ? seen_eff
                                                                : IDX_W'(seen_eff + 1'b1);
                    failed_next       = failed_eff;
                    priority if (failed_eff)
                    begin
                        code_next  = ST_SKIPPED;
                        state_next = S_FINISH;
                    end
                    else if (count_eff >= CNT_W'(MAX_ENTRIES))
                    begin
                        code_next   = ST_FULL;
                        failed_next = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        arith_start = 1'b1;
                        state_next  = S_ARITH;
                    end
                end
            end
            S_ARITH:
            begin
                if (arith_res.done)
                begin
                    if (arith_res.code != ST_OK)
                    begin
                        code_next   = arith_res.code;
                        failed_next = 1'b1;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    code_next  = scan_res.code;
                    state_next = S_FINISH;
                    if (scan_res.code == ST_OK)
                    begin
                        ram_wr.we         = 1'b1;
                        stored_count_next = CNT_W'(stored_count_reg + 1'b1);
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            stored_count_reg <= '0;
            seen_index_reg   <= '0;
            failed_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
            file_limit_reg   <= '0;
            header_limit_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            stored_count_reg <= stored_count_next;
            seen_index_reg   <= seen_index_next;
            failed_reg       <= failed_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    CFG_FILE_SIZE:   file_limit_reg   <= cfg.data;
                    CFG_HEADER_SIZE: header_limit_reg <= cfg.data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        if (accept)
        begin
            pos_reg  <= seen_eff;
            item_reg <= '{
                first_entry:   item.first_entry,
                block_id:      item.block_id,
                block_offset:  item.block_offset,
                block_length:  item.block_length,
                element_count: item.element_count,
                element_size:  item.element_size
            };
        end
        if (load_out)
        begin
            out_status_reg <= code_reg;
            out_index_reg  <= pos_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.entry_index = out_index_reg;

endmodule

`default_nettype wire

FILE: rtl/bdv_entry_ram.sv
// ----------------------------------------------------------------------------
// bdv_entry_ram
// Entry table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdv_entry_ram import bdv_pkg::*; (
    input  wire logic    clk,
    input  wire ram_rd_t rd,
    input  wire ram_wr_t wr,
    output entry_t       rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/bdv_arith_check.sv
// ----------------------------------------------------------------------------
// bdv_arith_check
// Alignment, end-of-block, product and header checks of one entry. The
// 64x64 product is built from four 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module bdv_arith_check import bdv_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire item_t             item,
    input  wire logic [DATA_W-1:0] file_limit,
    input  wire logic [DATA_W-1:0] header_limit,
    output check_res_t             res,
    output logic [DATA_W-1:0]      end_off
);

    localparam logic [2:0] STEP_IDLE = 3'd0;
    localparam logic [2:0] STEP_LAST = 3'd6;

    logic [2:0]          step_reg;
    logic [DATA_W:0]     sum_reg;
    logic [63:0]         pp_reg;
    logic [1:0]          pp_sh_reg;
    logic [127:0]        acc_reg;
    check_res_t          res_reg;

    logic [1:0]          pp_sel;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [1:0]          mul_sh;
    logic [127:0]        pp_shifted;
    status_t             code;
    logic                misaligned;

    assign pp_sel = 2'(step_reg - 3'd1);
    assign mul_a  = pp_sel[1] ? item.element_count[63:32] : item.element_count[31:0];
    assign mul_b  = pp_sel[0] ? item.element_size[63:32]  : item.element_size[31:0];
    assign mul_sh = {1'b0, pp_sel[1]} + {1'b0, pp_sel[0]};

    always_comb
    begin
        unique case (pp_sh_reg)
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = '0;
        endcase
    end

    assign misaligned = (item.block_offset & ALIGN_MASK) != '0;

    always_comb
    begin
        priority if (misaligned)
            code = ST_MISALIGNED;
        else if (sum_reg[DATA_W] || (sum_reg[DATA_W-1:0] > file_limit))
            code = ST_PAST_END;
        else if ((item.element_size != '0) && (acc_reg[127:64] != '0))
            code = ST_PRODUCT;
        else if ((item.element_size != '0) && (acc_reg[63:0] != item.block_length))
            code = ST_MISMATCH;
        else if ((item.block_length != '0) && (item.block_offset < header_limit))
            code = ST_OVER_HEADER;
        else
            code = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            res_reg  <= '{done: 1'b0, code: ST_OK};
        end
        else
        begin
            res_reg.done <= 1'b0;
            if (start)
            begin
                step_reg <= 3'd1;
            end
            else if (step_reg == STEP_LAST)
            begin
                step_reg     <= STEP_IDLE;
                res_reg.done <= 1'b1;
                res_reg.code <= code;
            end
            else if (step_reg != STEP_IDLE)
            begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // multiply in steps 1..4, accumulate in steps 2..5
    always_ff @(posedge clk)
    begin
        if ((step_reg >= 3'd1) && (step_reg <= 3'd4))
        begin
            pp_reg    <= mul_a * mul_b;
            pp_sh_reg <= mul_sh;
        end
        if (step_reg == 3'd1)
        begin
            sum_reg <= {1'b0, item.block_offset} + {1'b0, item.block_length};
            acc_reg <= '0;
        end
        else if ((step_reg >= 3'd2) && (step_reg <= 3'd5))
        begin
            acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign res     = res_reg;
    assign end_off = sum_reg[DATA_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/bdv_table_scan.sv
// ----------------------------------------------------------------------------
// bdv_table_scan
// Walks the stored entries in table order, one RAM read per cycle, and stops
// at the first duplicate id or overlapping range.
// ----------------------------------------------------------------------------
`default_nettype none

module bdv_table_scan import bdv_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] count,
    input  wire entry_t           probe,
    output ram_rd_t               rd,
    input  wire entry_t           rd_data,
    output check_res_t            res
);

    logic             busy_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic             dvalid_reg;
    logic             last_reg;
    check_res_t       res_reg;

    logic dup;
    logic ovl;
    logic finish;
    logic issue;

    assign dup = rd_data.id == probe.id;
    assign ovl = probe.nonempty && rd_data.nonempty &&
                 !((probe.off >= rd_data.end_off) || (rd_data.off >= probe.end_off));

    assign finish = dvalid_reg && (dup || ovl || last_reg);
    assign issue  = busy_reg && !finish && (rd_ptr_reg != count);

    assign rd.en   = issue;
    assign rd.addr = rd_ptr_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            rd_ptr_reg <= '0;
            dvalid_reg <= 1'b0;
            last_reg   <= 1'b0;
            res_reg    <= '{done: 1'b0, code: ST_OK};
        end
        else if (start)
        begin
            busy_reg     <= count != '0;
            rd_ptr_reg   <= '0;
            dvalid_reg   <= 1'b0;
            last_reg     <= 1'b0;
            res_reg.done <= count == '0;
            res_reg.code <= ST_OK;
        end
        else
        begin
            res_reg.done <= 1'b0;
            dvalid_reg   <= issue;
            last_reg     <= issue && (CNT_W'(rd_ptr_reg + 1'b1) == count);
            if (issue)
            begin
                rd_ptr_reg <= CNT_W'(rd_ptr_reg + 1'b1);
            end
            if (finish)
            begin
                busy_reg     <= 1'b0;
                res_reg.done <= 1'b1;
                priority if (dup)
                    res_reg.code <= ST_DUPLICATE;
                else if (ovl)
                    res_reg.code <= ST_OVERLAP;
                else
                    res_reg.code <= ST_OK;
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/bdv_checker.sv
// ----------------------------------------------------------------------------
// bdv_checker
// Port-level checks of the directory validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "block_directory_validator_core_defines.svh"

module bdv_checker import bdv_pkg::*; (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                item_valid,
    input wire logic                item_ready,
    input wire logic                result_valid,
    input wire logic                result_ready,
    input wire logic [STATUS_W-1:0] result_status,
    input wire logic [IDX_W-1:0]    result_entry_index
);

    // one entry at a time: taking an entry drops ready
    `BDV_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready, "ready after take")

    `BDV_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_status) && $stable(result_entry_index), "stalled result changed")

    // a new status is only loaded while the entry side is closed
    `BDV_ASSERT(a_load_while_busy, $rose(result_valid), !$past(item_ready), "status loaded while idle")

    // position zero always starts with a clear failure mark
    `BDV_ASSERT(a_no_skip_at_start, result_valid, !((result_status == ST_SKIPPED) && (result_entry_index == '0)), "skip at position zero")

    `BDV_ASSERT(a_full_needs_entries, result_valid && (result_status == ST_FULL), result_entry_index >= IDX_W'(MAX_ENTRIES), "table full too early")

endmodule

bind block_directory_validator_core bdv_checker u_bdv_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item.valid),
    .item_ready         (item.ready),
    .result_valid       (result.valid),
    .result_ready       (result.ready),
    .result_status      (result.status),
    .result_entry_index (result.entry_index)
);

`default_nettype wire
